// ===== design/tccw_pkg.sv =====
// Shared types, constants and geometry of the text console character writer.
package tccw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int NCELLS = COLS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int SUM_W  = ADDR_W + 1;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CH_W   = 8;

  localparam logic [CH_W-1:0]   CH_NEWLINE   = 8'h0A;
  localparam logic [CH_W-1:0]   CH_RETURN    = 8'h0D;
  localparam logic [CH_W-1:0]   CH_BACKSPACE = 8'h08;
  localparam logic [CH_W-1:0]   CH_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic exec;
    logic scr_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scr_last;
    logic exec_scroll;
    logic can_load;
  } status_t;

endpackage

// ===== design/text_console_char_writer.sv =====
// Top level of the text console character writer.
// A console of 80 columns by 25 rows of 16-bit cells (attribute high byte,
// character low byte) with a cursor. Each request gives exactly one result,
// which carries the cursor after the request. A read or a write reaches the
// result register through the execute and done states, and the next request
// is accepted once the controller is back in idle; a write that scrolls adds
// a sweep in which the single store port blanks the old top row, one column
// per cycle, and that row then becomes the bottom row through a circular row
// offset. A result that is not taken holds the next request back before its
// result register load.
// After reset a clearing pass writes every cell, one per cycle, and no
// request is accepted until it ends; attribute writes are taken at any
// time. A new request is taken while the previous result still waits.
module text_console_char_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // ch [7:0], read_addr [18:8], zero [23:19]
  input  logic        in_tuser,   // req_type [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_data [15:0], cur_col [22:16], cur_row [27:23], cur_linear [38:28],
  // did_scroll [39]
  output logic [39:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  tccw_pkg::cmd_t    cmd;
  tccw_pkg::status_t stat;

  logic [tccw_pkg::CELL_W-1:0] cell_data;
  logic [tccw_pkg::COL_W-1:0]  cur_col;
  logic [tccw_pkg::ROW_W-1:0]  cur_row;
  logic [tccw_pkg::ADDR_W-1:0] cur_linear;
  logic                        did_scroll;

  tccw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  tccw_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_req_type   (in_tuser),
    .in_ch         (in_tdata[7:0]),
    .in_read_addr  (in_tdata[18:8]),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_cell_data (cell_data),
    .out_cur_col   (cur_col),
    .out_cur_row   (cur_row),
    .out_cur_linear(cur_linear),
    .out_did_scroll(did_scroll)
  );

  assign out_tdata = {did_scroll, cur_linear, cur_row, cur_col, cell_data};

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another was in flight");

  // A scroll always leaves the cursor at column 0 of the last row.
  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && did_scroll |->
      (cur_row == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1)) && (cur_col == '0))
    else $error("scroll result with cursor off the start of the last row");

  // The linear position tracks row and column.
  a_linear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (32'(cur_linear) == 32'(cur_row) * tccw_pkg::COLS + 32'(cur_col)) &&
      (32'(cur_col) < tccw_pkg::COLS) && (32'(cur_row) < tccw_pkg::ROWS))
    else $error("cursor linear position out of step with row and column");

endmodule

// ===== design/tccw_ram.sv =====
// Generic single-port RAM with registered read data.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tccw_ctrl.sv =====
// Controller state machine: clearing pass, request execution, scroll sweep, result hand-off.
module tccw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tccw_pkg::status_t stat,
  output tccw_pkg::cmd_t    cmd
);

  tccw_pkg::state_t state_r;
  tccw_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tccw_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      tccw_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = tccw_pkg::ST_EXEC;
        end
      end
      tccw_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.exec_scroll) begin
          state_nxt = tccw_pkg::ST_SCROLL;
        end else begin
          state_nxt = tccw_pkg::ST_DONE;
        end
      end
      tccw_pkg::ST_SCROLL: begin
        cmd.scr_wr = 1'b1;
        if (stat.scr_last) begin
          state_nxt = tccw_pkg::ST_DONE;
        end
      end
      tccw_pkg::ST_DONE: begin
        // The result register may still hold the previous result.
        if (stat.can_load) begin
          cmd.load_out = 1'b1;
          state_nxt    = tccw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tccw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/tccw_dp.sv =====
// Datapath: cursor registers, circular row offset, cell store and result register.
module tccw_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tccw_pkg::cmd_t                    cmd,
  output tccw_pkg::status_t                 stat,
  input  logic                              in_req_type,
  input  logic [tccw_pkg::CH_W-1:0]         in_ch,
  input  logic [tccw_pkg::ADDR_W-1:0]       in_read_addr,
  input  logic                              cfg_wr_en,
  input  logic [tccw_pkg::ATTR_W-1:0]       cfg_wr_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tccw_pkg::CELL_W-1:0]       out_cell_data,
  output logic [tccw_pkg::COL_W-1:0]        out_cur_col,
  output logic [tccw_pkg::ROW_W-1:0]        out_cur_row,
  output logic [tccw_pkg::ADDR_W-1:0]       out_cur_linear,
  output logic                              out_did_scroll
);

  localparam int AW = tccw_pkg::ADDR_W;
  localparam int SW = tccw_pkg::SUM_W;
  localparam int CW = tccw_pkg::COL_W;
  localparam int RW = tccw_pkg::ROW_W;

  // Logical cell index plus the offset of the top row, folded back into the store.
  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] lin,
                                              input logic [AW-1:0] base);
    logic [SW-1:0] sum;
    sum = {1'b0, lin} + {1'b0, base};
    if (sum >= SW'(tccw_pkg::NCELLS)) begin
      sum = sum - SW'(tccw_pkg::NCELLS);
    end
    return sum[AW-1:0];
  endfunction

  logic [tccw_pkg::ATTR_W-1:0] attr_r;
  logic [CW-1:0]               col_r, col_nxt;
  logic [RW-1:0]               row_r, row_nxt;
  logic [AW-1:0]               lin_r, lin_nxt;
  logic [AW-1:0]               top_base_r;
  logic [AW-1:0]               cnt_r;
  logic                        req_r;
  logic [tccw_pkg::CH_W-1:0]   ch_r;
  logic [AW-1:0]               addr_r;
  logic                        in_range_r;
  logic                        scroll_r, scroll_nxt;
  logic                        out_valid_r;
  logic [tccw_pkg::CELL_W-1:0] cell_r;
  logic [CW-1:0]               ocol_r;
  logic [RW-1:0]               orow_r;
  logic [AW-1:0]               olin_r;
  logic                        oscroll_r;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_addr;
  logic [tccw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  logic                        is_nl, is_cr, is_bs, is_print;
  logic                        col_nz, inc_row, wr_en;
  logic [AW-1:0]               wr_lin;
  logic [SW-1:0]               lin_sol;

  tccw_ram #(
    .WIDTH(tccw_pkg::CELL_W),
    .DEPTH(tccw_pkg::NCELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Decode of the latched character and the cursor move it causes.
  always_comb begin
    is_nl    = (ch_r == tccw_pkg::CH_NEWLINE);
    is_cr    = (ch_r == tccw_pkg::CH_RETURN);
    is_bs    = (ch_r == tccw_pkg::CH_BACKSPACE);
    is_print = !is_nl && !is_cr && !is_bs;
    col_nz   = (col_r != '0);
    wr_en    = (req_r == tccw_pkg::REQ_WRITE) && (is_print || (is_bs && col_nz));
    wr_lin   = is_bs ? (lin_r - AW'(1)) : lin_r;
    lin_sol  = SW'(lin_r) - SW'(col_r);

    col_nxt  = col_r;
    row_nxt  = row_r;
    lin_nxt  = lin_r;
    inc_row  = 1'b0;
    if (is_nl) begin
      col_nxt = '0;
      inc_row = 1'b1;
      lin_nxt = AW'(lin_sol + SW'(tccw_pkg::COLS));
    end else if (is_cr) begin
      col_nxt = '0;
      lin_nxt = lin_sol[AW-1:0];
    end else if (is_bs) begin
      if (col_nz) begin
        col_nxt = col_r - CW'(1);
        lin_nxt = lin_r - AW'(1);
      end
    end else begin
      lin_nxt = lin_r + AW'(1);
      if (col_r == CW'(tccw_pkg::COLS - 1)) begin
        col_nxt = '0;
        inc_row = 1'b1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end

    scroll_nxt = 1'b0;
    if (inc_row) begin
      if (row_r == RW'(tccw_pkg::ROWS - 1)) begin
        scroll_nxt = 1'b1;
        lin_nxt    = AW'((tccw_pkg::ROWS - 1) * tccw_pkg::COLS);
      end else begin
        row_nxt = row_r + RW'(1);
      end
    end
    if (req_r == tccw_pkg::REQ_READ) begin
      scroll_nxt = 1'b0;
    end
  end

  // Store port: clearing pass, scroll blanking of the old top row, or the request itself.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = cnt_r;
    ram_wdata = {tccw_pkg::ATTR_RESET, tccw_pkg::CH_SPACE};
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.scr_wr) begin
      ram_we    = 1'b1;
      ram_addr  = top_base_r + cnt_r;
      ram_wdata = {attr_r, tccw_pkg::CH_SPACE};
    end else if (cmd.exec) begin
      if (req_r == tccw_pkg::REQ_READ) begin
        ram_re   = in_range_r;
        ram_addr = phys_addr(addr_r, top_base_r);
      end else begin
        ram_we    = wr_en;
        ram_addr  = phys_addr(wr_lin, top_base_r);
        ram_wdata = {attr_r, (is_print ? ch_r : tccw_pkg::CH_SPACE)};
      end
    end
  end

  always_comb begin
    stat.clr_last    = (cnt_r == AW'(tccw_pkg::NCELLS - 1));
    stat.scr_last    = (cnt_r == AW'(tccw_pkg::COLS - 1));
    stat.exec_scroll = scroll_nxt;
    stat.can_load    = !out_valid_r || out_ready;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= tccw_pkg::ATTR_RESET;
      col_r       <= '0;
      row_r       <= '0;
      lin_r       <= '0;
      top_base_r  <= '0;
      cnt_r       <= '0;
      scroll_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        scroll_r <= scroll_nxt;
        if (req_r == tccw_pkg::REQ_WRITE) begin
          col_r <= col_nxt;
          row_r <= row_nxt;
          lin_r <= lin_nxt;
        end
      end
      if ((cmd.clr_wr && stat.clr_last) || (cmd.scr_wr && stat.scr_last)) begin
        cnt_r <= '0;
      end else if (cmd.clr_wr || cmd.scr_wr) begin
        cnt_r <= cnt_r + AW'(1);
      end
      // The blanked old top row becomes the bottom row.
      if (cmd.scr_wr && stat.scr_last) begin
        if (SW'(top_base_r) + SW'(tccw_pkg::COLS) >= SW'(tccw_pkg::NCELLS)) begin
          top_base_r <= '0;
        end else begin
          top_base_r <= top_base_r + AW'(tccw_pkg::COLS);
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r      <= in_req_type;
      ch_r       <= in_ch;
      addr_r     <= in_read_addr;
      in_range_r <= (in_read_addr < AW'(tccw_pkg::NCELLS));
    end
    if (cmd.load_out) begin
      cell_r    <= ((req_r == tccw_pkg::REQ_READ) && in_range_r) ? ram_rdata : '0;
      ocol_r    <= col_r;
      orow_r    <= row_r;
      olin_r    <= lin_r;
      oscroll_r <= scroll_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_data  = cell_r;
  assign out_cur_col    = ocol_r;
  assign out_cur_row    = orow_r;
  assign out_cur_linear = olin_r;
  assign out_did_scroll = oscroll_r;

endmodule

// ===== test/tb_text_console_char_writer.sv =====
// Self-checking testbench for the text console character writer.
`timescale 1ns / 100ps

module tb_text_console_char_writer;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int PHASE_ITEMS    = 308;

  typedef struct packed {
    logic                          req_type;
    logic [tccw_pkg::CH_W-1:0]     ch;
    logic [tccw_pkg::ADDR_W-1:0]   addr;
  } console_req_t;

  typedef struct packed {
    logic [tccw_pkg::CELL_W-1:0] cell_data;
    logic [tccw_pkg::COL_W-1:0]  col;
    logic [tccw_pkg::ROW_W-1:0]  row;
    logic [tccw_pkg::ADDR_W-1:0] lin;
    logic                        scrolled;
  } cursor_report_t;

  typedef struct {
    console_req_t   rq;
    logic           fixed;
    cursor_report_t rep;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  // Shadow of the console: cell store, cursor and current attribute.
  logic [tccw_pkg::CELL_W-1:0] screen_img [tccw_pkg::NCELLS];
  int                          cur_x;
  int                          cur_y;
  logic [tccw_pkg::ATTR_W-1:0] pen_attr;

  cursor_report_t reports_due [$];
  logic           fix_en = 1'b0;
  cursor_report_t fix_rep = '0;
  logic           quiet = 1'b0;
  int             mismatches = 0;
  int             stall_cycles = 0;

  text_console_char_writer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic cursor_report_t console_apply(console_req_t rq);
    cursor_report_t rep;
    int i;
    rep = '0;
    if (rq.req_type == tccw_pkg::REQ_READ) begin
      if (rq.addr < tccw_pkg::NCELLS) rep.cell_data = screen_img[rq.addr];
    end else begin
      case (rq.ch)
        tccw_pkg::CH_NEWLINE: begin
          cur_x = 0;
          cur_y++;
        end
        tccw_pkg::CH_RETURN: cur_x = 0;
        tccw_pkg::CH_BACKSPACE: begin
          if (cur_x > 0) begin
            cur_x--;
            screen_img[cur_y * tccw_pkg::COLS + cur_x] = {pen_attr, tccw_pkg::CH_SPACE};
          end
        end
        default: begin
          screen_img[cur_y * tccw_pkg::COLS + cur_x] = {pen_attr, rq.ch};
          cur_x++;
        end
      endcase
      if (cur_x >= tccw_pkg::COLS) begin
        cur_x = 0;
        cur_y++;
      end
      if (cur_y >= tccw_pkg::ROWS) begin
        for (i = 0; i < tccw_pkg::NCELLS - tccw_pkg::COLS; i++)
          screen_img[i] = screen_img[i + tccw_pkg::COLS];
        for (i = tccw_pkg::NCELLS - tccw_pkg::COLS; i < tccw_pkg::NCELLS; i++)
          screen_img[i] = {pen_attr, tccw_pkg::CH_SPACE};
        cur_y = tccw_pkg::ROWS - 1;
        rep.scrolled = 1'b1;
      end
    end
    rep.col = tccw_pkg::COL_W'(cur_x);
    rep.row = tccw_pkg::ROW_W'(cur_y);
    rep.lin = tccw_pkg::ADDR_W'(cur_y * tccw_pkg::COLS + cur_x);
    return rep;
  endfunction

  task automatic report_field(string nm, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, nm, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cursor_report_t want;
    cursor_report_t got;
    if (cfg_wr_en) pen_attr = cfg_wr_data;
    if (rst_n && in_tvalid && in_tready) begin
      want = console_apply({in_tuser, in_tdata[7:0], in_tdata[18:8]});
      if (fix_en) want = fix_rep;
      reports_due.push_back(want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.cell_data = out_tdata[15:0];
      got.col       = out_tdata[22:16];
      got.row       = out_tdata[27:23];
      got.lin       = out_tdata[38:28];
      got.scrolled  = out_tdata[39];
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, out_tdata);
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        report_field("cell_data", int'(want.cell_data), int'(got.cell_data));
        report_field("cur_col", int'(want.col), int'(got.col));
        report_field("cur_row", int'(want.row), int'(got.row));
        report_field("cur_linear", int'(want.lin), int'(got.lin));
        report_field("did_scroll", int'(want.scrolled), int'(got.scrolled));
      end
    end
  end

  // Random back-pressure on results, switched off during the quiet phase.
  always @(negedge clk) begin
    out_tready = quiet || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, stall_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Entered just after a rising edge; returns at the edge that takes the request.
  task automatic send_request(console_req_t rq, logic fixed, cursor_report_t rep);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {5'b0, rq.addr, rq.ch};
    in_tuser  = rq.req_type;
    fix_en    = fixed;
    fix_rep   = rep;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Lets every outstanding request finish so the attribute can be changed safely.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    fix_en    = 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic plan_row_t mk(logic rt, logic [7:0] c, logic [10:0] a, logic fx,
                                   logic [15:0] cell_v, int col, int row, int lin);
    plan_row_t p;
    p.rq    = {rt, c, a};
    p.fixed = fx;
    p.rep   = {cell_v, col[tccw_pkg::COL_W-1:0], row[tccw_pkg::ROW_W-1:0],
               lin[tccw_pkg::ADDR_W-1:0], 1'b0};
    return p;
  endfunction

  initial begin
    plan_row_t                   plan [$];
    logic [tccw_pkg::ATTR_W-1:0] attr_set [4];
    console_req_t                rq;
    cursor_report_t              none;
    int                          lin;
    int                          roll;
    int                          nl_rate;
    logic                        long_lines;

    none     = '0;
    pen_attr = tccw_pkg::ATTR_RESET;
    cur_x    = 0;
    cur_y    = 0;
    foreach (screen_img[i]) screen_img[i] = {tccw_pkg::ATTR_RESET, tccw_pkg::CH_SPACE};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Cleared store, reads past the end, backspace at column 0, extreme bytes.
    plan.push_back(mk(tccw_pkg::REQ_READ, 8'h00, 11'd0, 1'b1, 16'h0720, 0, 0, 0));
    plan.push_back(mk(tccw_pkg::REQ_READ, 8'hFF, 11'd1999, 1'b1, 16'h0720, 0, 0, 0));
    plan.push_back(mk(tccw_pkg::REQ_READ, 8'h00, 11'd2000, 1'b1, 16'h0000, 0, 0, 0));
    plan.push_back(mk(tccw_pkg::REQ_READ, 8'h00, 11'd2047, 1'b1, 16'h0000, 0, 0, 0));
    plan.push_back(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_BACKSPACE, 11'd0, 1'b1, 16'h0000,
                      0, 0, 0));
    plan.push_back(mk(tccw_pkg::REQ_WRITE, 8'h41, 11'd2047, 1'b1, 16'h0000, 1, 0, 1));
    plan.push_back(mk(tccw_pkg::REQ_WRITE, 8'hFF, 11'd0, 1'b1, 16'h0000, 2, 0, 2));
    plan.push_back(mk(tccw_pkg::REQ_WRITE, 8'h00, 11'd0, 1'b1, 16'h0000, 3, 0, 3));
    plan.push_back(mk(tccw_pkg::REQ_WRITE, 8'h80, 11'd0, 1'b1, 16'h0000, 4, 0, 4));
    plan.push_back(mk(tccw_pkg::REQ_READ, 8'h00, 11'd1, 1'b1, 16'h07FF, 4, 0, 4));
    plan.push_back(mk(tccw_pkg::REQ_READ, 8'h00, 11'd3, 1'b1, 16'h0780, 4, 0, 4));
    plan.push_back(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_BACKSPACE, 11'd0, 1'b1, 16'h0000,
                      3, 0, 3));
    plan.push_back(mk(tccw_pkg::REQ_READ, 8'h00, 11'd3, 1'b1, 16'h0720, 3, 0, 3));
    plan.push_back(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_RETURN, 11'd0, 1'b1, 16'h0000,
                      0, 0, 0));
    plan.push_back(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_NEWLINE, 11'd0, 1'b1, 16'h0000,
                      0, 1, 80));
    plan.push_back(mk(tccw_pkg::REQ_WRITE, 8'h7E, 11'd0, 1'b0, 16'h0000, 0, 0, 0));
    plan.push_back(mk(tccw_pkg::REQ_READ, 8'h00, 11'd80, 1'b0, 16'h0000, 0, 0, 0));
    plan.push_back(mk(tccw_pkg::REQ_WRITE, 8'h09, 11'd0, 1'b0, 16'h0000, 0, 0, 0));
    plan.push_back(mk(tccw_pkg::REQ_READ, 8'h00, 11'd0, 1'b1, 16'h0741, 2, 1, 82));
    foreach (plan[i]) send_request(plan[i].rq, plan[i].fixed, plan[i].rep);

    attr_set[0] = 8'h00;
    attr_set[1] = 8'hFF;
    attr_set[2] = tccw_pkg::ATTR_W'($urandom_range(1, 254));
    attr_set[3] = tccw_pkg::ATTR_RESET;
    long_lines  = 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      @(negedge clk);
      cfg_wr_en   = 1'b1;
      cfg_wr_data = attr_set[phase];
      @(negedge clk);
      cfg_wr_en = 1'b0;
      @(posedge clk);
      quiet = (phase == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Alternate between chatty text and long lines that wrap and scroll.
        if (n % 40 == 0) long_lines = ($urandom_range(0, 1) == 1);
        nl_rate = long_lines ? 5 : 90;
        rq.req_type = ($urandom_range(0, 99) < 15) ? tccw_pkg::REQ_READ : tccw_pkg::REQ_WRITE;
        rq.addr     = tccw_pkg::ADDR_W'($urandom_range(0, 2047));
        if (rq.req_type == tccw_pkg::REQ_READ) begin
          roll = $urandom_range(0, 99);
          lin  = cur_y * tccw_pkg::COLS + cur_x;
          if (roll < 60) begin
            rq.addr = (lin >= 4) ? tccw_pkg::ADDR_W'(lin - int'($urandom_range(0, 4)))
                                 : tccw_pkg::ADDR_W'(lin);
          end else if (roll < 90) begin
            rq.addr = tccw_pkg::ADDR_W'($urandom_range(0, tccw_pkg::NCELLS - 1));
          end else begin
            rq.addr = tccw_pkg::ADDR_W'($urandom_range(tccw_pkg::NCELLS, 2047));
          end
        end
        roll = $urandom_range(0, 999);
        if (roll < nl_rate) rq.ch = tccw_pkg::CH_NEWLINE;
        else if (roll < nl_rate + 30) rq.ch = tccw_pkg::CH_RETURN;
        else if (roll < nl_rate + 80) rq.ch = tccw_pkg::CH_BACKSPACE;
        else if (roll < nl_rate + 130) rq.ch = tccw_pkg::CH_W'($urandom_range(0, 255));
        else rq.ch = tccw_pkg::CH_W'($urandom_range(32, 126));
        send_request(rq, 1'b0, none);
      end
      quiet = 1'b0;
    end

    settle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tccw_pkg.sv
design/tccw_ram.sv
design/tccw_ctrl.sv
design/tccw_dp.sv
design/text_console_char_writer.sv
test/tb_text_console_char_writer.sv
